FILE: hdl/pwdf_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants for the peer wire handshake deframer.
// No dependencies; imported by every module of the block.
package pwdf_pkg;

    localparam int unsigned MAX_MESSAGE_DEF = 1048576;
    localparam int unsigned CFG_DATA_W      = 64;
    localparam int unsigned CFG_INDEX_W     = 3;
    localparam int unsigned ID_BYTES        = 20;
    localparam int unsigned PSTR_LEN        = 19;
    localparam int unsigned RSV_LEN         = 8;
    localparam int unsigned MAX_MSG_TYPE    = 8;

    // Phase codes double as the field_kind tag of each byte.
    typedef enum logic [2:0] {
        PH_PLEN = 3'd0,
        PH_PSTR = 3'd1,
        PH_RSV  = 3'd2,
        PH_HASH = 3'd3,
        PH_PEER = 3'd4,
        PH_LEN  = 3'd5,
        PH_TYPE = 3'd6,
        PH_PAY  = 3'd7
    } phase_t;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_PROTO_LEN = 3'd1,
        ERR_STRING    = 3'd2,
        ERR_HASH      = 3'd3,
        ERR_PEER      = 3'd4,
        ERR_TOO_LONG  = 3'd5,
        ERR_BAD_TYPE  = 3'd6
    } err_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_HASH_0_7   = 3'd0,
        CFG_HASH_8_15  = 3'd1,
        CFG_HASH_16_19 = 3'd2,
        CFG_PEER_0_7   = 3'd3,
        CFG_PEER_8_15  = 3'd4,
        CFG_PEER_16_19 = 3'd5,
        CFG_VERIFY     = 3'd6
    } cfg_index_t;

    // Byte 0 of each id sits in the top byte.
    typedef struct packed {
        logic [8*ID_BYTES-1:0] hash_id;
        logic [8*ID_BYTES-1:0] peer_id;
        logic                  verify_peer;
    } cfg_t;

    typedef struct packed {
        logic [7:0] data_byte;
        phase_t     field_kind;
        logic       msg_start;
        logic       msg_last;
        logic       keepalive;
        err_t       error_code;
    } result_t;

    function automatic logic [7:0] proto_char(input logic [4:0] idx);
        logic [7:0] c;
        unique case (idx)
            5'd0:    c = 8'h42; // B
            5'd1:    c = 8'h69; // i
            5'd2:    c = 8'h74; // t
            5'd3:    c = 8'h54; // T
            5'd4:    c = 8'h6f; // o
            5'd5:    c = 8'h72; // r
            5'd6:    c = 8'h72; // r
            5'd7:    c = 8'h65; // e
            5'd8:    c = 8'h6e; // n
            5'd9:    c = 8'h74; // t
            5'd10:   c = 8'h20; // space
            5'd11:   c = 8'h70; // p
            5'd12:   c = 8'h72; // r
            5'd13:   c = 8'h6f; // o
            5'd14:   c = 8'h74; // t
            5'd15:   c = 8'h6f; // o
            5'd16:   c = 8'h63; // c
            5'd17:   c = 8'h6f; // o
            5'd18:   c = 8'h6c; // l
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Pick byte idx of a 20-byte id, byte 0 most significant.
    function automatic logic [7:0] id_byte(input logic [8*ID_BYTES-1:0] id,
                                           input logic [4:0] idx);
        logic [7:0] b;
        b = 8'h00;
        for (int i = 0; i < ID_BYTES; i++) begin
            if (idx == 5'(i)) begin
                b = id[8*(ID_BYTES-1-i) +: 8];
            end
        end
        return b;
    endfunction

endpackage

FILE: hdl/pwdf_cfg_regs.sv
`timescale 1ns / 1ps
// Configuration register file: expected info hash, peer id and verify flag.
// Depends on pwdf_pkg.
module pwdf_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [pwdf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [pwdf_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output pwdf_pkg::cfg_t                   cfg
);
    import pwdf_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_HASH_0_7:   cfg_reg.hash_id[159:96] <= cfg_wdata;
                CFG_HASH_8_15:  cfg_reg.hash_id[95:32]  <= cfg_wdata;
                CFG_HASH_16_19: cfg_reg.hash_id[31:0]   <= cfg_wdata[31:0];
                CFG_PEER_0_7:   cfg_reg.peer_id[159:96] <= cfg_wdata;
                CFG_PEER_8_15:  cfg_reg.peer_id[95:32]  <= cfg_wdata;
                CFG_PEER_16_19: cfg_reg.peer_id[31:0]   <= cfg_wdata[31:0];
                CFG_VERIFY:     cfg_reg.verify_peer     <= cfg_wdata[0];
                default: begin
                    // unmapped index: drop the write
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: hdl/pwdf_parser.sv
`timescale 1ns / 1ps
// Handshake checker and message deframer: parse state plus the per-byte
// tagging logic. Depends on pwdf_pkg.
module pwdf_parser #(
    parameter int unsigned MAX_MESSAGE = pwdf_pkg::MAX_MESSAGE_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  logic [7:0]        rx_byte,
    input  pwdf_pkg::cfg_t    cfg,
    output pwdf_pkg::result_t result
);
    import pwdf_pkg::*;

    localparam int unsigned LEN_W = $clog2(MAX_MESSAGE + 1);

    phase_t           phase_reg, phase_next;
    logic [LEN_W-1:0] byte_count_reg, byte_count_next;
    logic [31:0]      length_accum_reg, length_accum_next;
    logic [LEN_W-1:0] msg_length_reg, msg_length_next;
    err_t             latched_error_reg, latched_error_next;
    logic             mismatch_reg, mismatch_next;

    logic [LEN_W-1:0] count_inc;
    logic [31:0]      accum_shift;
    logic             byte_diff;
    err_t             err;

    assign count_inc   = byte_count_reg + LEN_W'(1);
    assign accum_shift = {length_accum_reg[23:0], rx_byte};

    always_comb begin
        unique case (phase_reg)
            PH_PSTR: byte_diff = (rx_byte != proto_char(byte_count_reg[4:0]));
            PH_HASH: byte_diff = (rx_byte != id_byte(cfg.hash_id, byte_count_reg[4:0]));
            PH_PEER: byte_diff = (rx_byte != id_byte(cfg.peer_id, byte_count_reg[4:0]));
            default: byte_diff = 1'b0;
        endcase
    end

    // Per-byte tags and the error raised by the current byte.
    always_comb begin
        err                = ERR_NONE;
        result.data_byte   = rx_byte;
        result.field_kind  = phase_reg;
        result.msg_start   = 1'b0;
        result.msg_last    = 1'b0;
        result.keepalive   = 1'b0;

        if (latched_error_reg == ERR_NONE) begin
            unique case (phase_reg)
                PH_PLEN: begin
                    if (rx_byte != 8'(PSTR_LEN)) begin
                        err = ERR_PROTO_LEN;
                    end
                end
                PH_PSTR: begin
                    if (count_inc >= LEN_W'(PSTR_LEN) && (mismatch_reg | byte_diff)) begin
                        err = ERR_STRING;
                    end
                end
                PH_RSV: begin
                end
                PH_HASH: begin
                    if (count_inc >= LEN_W'(ID_BYTES) && (mismatch_reg | byte_diff)) begin
                        err = ERR_HASH;
                    end
                end
                PH_PEER: begin
                    if (count_inc >= LEN_W'(ID_BYTES) && (mismatch_reg | byte_diff) &&
                        cfg.verify_peer) begin
                        err = ERR_PEER;
                    end
                end
                PH_LEN: begin
                    if (byte_count_reg[1:0] == 2'd3) begin
                        if (accum_shift > 32'(MAX_MESSAGE)) begin
                            err = ERR_TOO_LONG;
                        end else if (accum_shift == 32'd0) begin
                            result.keepalive = 1'b1;
                        end
                    end
                end
                PH_TYPE: begin
                    result.msg_start = 1'b1;
                    if (rx_byte > 8'(MAX_MSG_TYPE)) begin
                        err = ERR_BAD_TYPE;
                    end else if (msg_length_reg <= LEN_W'(1)) begin
                        result.msg_last = 1'b1;
                    end
                end
                PH_PAY: begin
                    if (count_inc >= msg_length_reg) begin
                        result.msg_last = 1'b1;
                    end
                end
                default: begin
                end
            endcase
            result.error_code = err;
        end else begin
            // frozen: pass the byte through with the latched code
            result.error_code = latched_error_reg;
        end
    end

    // Next parse state.
    always_comb begin
        phase_next         = phase_reg;
        byte_count_next    = byte_count_reg;
        length_accum_next  = length_accum_reg;
        msg_length_next    = msg_length_reg;
        mismatch_next      = mismatch_reg;

        if (latched_error_reg == ERR_NONE) begin
            unique case (phase_reg)
                PH_PLEN: begin
                    if (err == ERR_NONE) begin
                        phase_next      = PH_PSTR;
                        byte_count_next = '0;
                        mismatch_next   = 1'b0;
                    end
                end
                PH_PSTR: begin
                    mismatch_next   = mismatch_reg | byte_diff;
                    byte_count_next = count_inc;
                    if (count_inc >= LEN_W'(PSTR_LEN) && err == ERR_NONE) begin
                        phase_next      = PH_RSV;
                        byte_count_next = '0;
                    end
                end
                PH_RSV: begin
                    byte_count_next = count_inc;
                    if (count_inc >= LEN_W'(RSV_LEN)) begin
                        phase_next      = PH_HASH;
                        byte_count_next = '0;
                        mismatch_next   = 1'b0;
                    end
                end
                PH_HASH: begin
                    mismatch_next   = mismatch_reg | byte_diff;
                    byte_count_next = count_inc;
                    if (count_inc >= LEN_W'(ID_BYTES) && err == ERR_NONE) begin
                        phase_next      = PH_PEER;
                        byte_count_next = '0;
                        mismatch_next   = 1'b0;
                    end
                end
                PH_PEER: begin
                    mismatch_next   = mismatch_reg | byte_diff;
                    byte_count_next = count_inc;
                    if (count_inc >= LEN_W'(ID_BYTES) && err == ERR_NONE) begin
                        phase_next        = PH_LEN;
                        byte_count_next   = '0;
                        length_accum_next = '0;
                        mismatch_next     = 1'b0;
                    end
                end
                PH_LEN: begin
                    length_accum_next = accum_shift;
                    byte_count_next   = count_inc;
                    if (byte_count_reg[1:0] == 2'd3) begin
                        byte_count_next   = '0;
                        length_accum_next = '0;
                        if (err == ERR_NONE && accum_shift != 32'd0) begin
                            msg_length_next = accum_shift[LEN_W-1:0];
                            phase_next      = PH_TYPE;
                        end
                    end
                end
                PH_TYPE: begin
                    if (err == ERR_NONE) begin
                        if (msg_length_reg <= LEN_W'(1)) begin
                            phase_next      = PH_LEN;
                            byte_count_next = '0;
                        end else begin
                            phase_next      = PH_PAY;
                            byte_count_next = LEN_W'(1);
                        end
                    end
                end
                PH_PAY: begin
                    byte_count_next = count_inc;
                    if (count_inc >= msg_length_reg) begin
                        phase_next      = PH_LEN;
                        byte_count_next = '0;
                    end
                end
                default: begin
                    phase_next = phase_reg;
                end
            endcase
        end

        latched_error_next = (err != ERR_NONE) ? err : latched_error_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_PLEN;
            byte_count_reg    <= '0;
            length_accum_reg  <= '0;
            msg_length_reg    <= '0;
            latched_error_reg <= ERR_NONE;
            mismatch_reg      <= 1'b0;
        end else if (advance) begin
            if (latched_error_reg == ERR_NONE) begin
                phase_reg        <= phase_next;
                byte_count_reg   <= byte_count_next;
                length_accum_reg <= length_accum_next;
                msg_length_reg   <= msg_length_next;
                mismatch_reg     <= mismatch_next;
            end
            latched_error_reg <= latched_error_next;
        end
    end

endmodule

FILE: hdl/peer_wire_handshake_deframer_core.sv
`timescale 1ns / 1ps
// Peer wire handshake deframer, top level.
// Depends on pwdf_pkg, pwdf_cfg_regs and pwdf_parser.
//
// Usage:
//   s_ channel (valid/ready) carries one received connection byte per
//   transaction. m_ channel (valid/ready) returns exactly one tagged result
//   per input byte: the byte itself, its field kind, message start/last
//   and keepalive flags, and the error code (first error latches).
//   Configuration: drive cfg_wr_en with cfg_index/cfg_wdata while the
//   block is idle; writes take effect on the same edge.
//   The byte lands in the input register on its accepting edge; advance then
//   moves its result into the result register, which drives m_valid.
//   Throughput: one byte per cycle while m_ready takes the results, set by
//   the combinational parse state update between the two registers.
//   Reset (aresetn low, synchronous): parser returns to the protocol
//   length byte, the latched error and all config registers clear, both
//   channels empty.
//   Receiver stall: the result register holds, the input register holds
//   one more byte, then s_ready drops until m_ready returns.
module peer_wire_handshake_deframer_core #(
    parameter int unsigned MAX_MESSAGE = pwdf_pkg::MAX_MESSAGE_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [pwdf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [pwdf_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [7:0]                       s_rx_byte,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [7:0]                       m_data_byte,
    output logic [2:0]                       m_field_kind,
    output logic                             m_msg_start,
    output logic                             m_msg_last,
    output logic                             m_keepalive,
    output logic [2:0]                       m_error_code
);
    import pwdf_pkg::*;

    cfg_t       cfg;
    result_t    result;
    result_t    out_reg;
    logic       out_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_valid_reg;
    logic       advance;

    // move the held byte into the result register when that slot frees up
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    pwdf_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    pwdf_parser #(
        .MAX_MESSAGE (MAX_MESSAGE)
    ) u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .rx_byte (in_byte_reg),
        .cfg     (cfg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_data_byte  = out_reg.data_byte;
    assign m_field_kind = out_reg.field_kind;
    assign m_msg_start  = out_reg.msg_start;
    assign m_msg_last   = out_reg.msg_last;
    assign m_keepalive  = out_reg.keepalive;
    assign m_error_code = out_reg.error_code;

endmodule

FILE: tb/sv/tb_peer_wire_handshake_deframer_core.sv
`timescale 1ns / 1ps
// Self-checking bench for peer_wire_handshake_deframer_core: a byte tagger model
// in a scoreboard class, random handshake and message streams, random stalls.
// Depends on pwdf_pkg and the core RTL only.
module tb_peer_wire_handshake_deframer_core;

    import pwdf_pkg::*;

    localparam int unsigned IDLE_PCT       = 9;
    localparam int unsigned SETTLE_CYCLES  = 4;
    localparam int unsigned WATCHDOG_LIMIT = 5000;
    localparam int unsigned TAIL_BYTES     = 200;
    localparam int unsigned REPORT_LIMIT   = 10;
    localparam logic [8*PSTR_LEN-1:0] PROTOCOL_NAME = "BitTorrent protocol";

    class byte_tag_scoreboard;
        logic [8*ID_BYTES-1:0] exp_hash;
        logic [8*ID_BYTES-1:0] peer_id;
        bit                    verify;
        phase_t                phase;
        int unsigned           count;
        logic [31:0]           len_accum;
        logic [31:0]           msg_len;
        err_t                  held_err;
        bit                    differs;
        result_t               expected_tags[$];
        int unsigned           faults;
        int unsigned           checked;
        int unsigned           msgs_closed;
        int unsigned           keepalives;

        function new();
            exp_hash    = '0;
            peer_id     = '0;
            verify      = 1'b0;
            phase       = PH_PLEN;
            count       = 0;
            len_accum   = '0;
            msg_len     = '0;
            held_err    = ERR_NONE;
            differs     = 1'b0;
            faults      = 0;
            checked     = 0;
            msgs_closed = 0;
            keepalives  = 0;
        endfunction

        function void write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_HASH_0_7:   exp_hash[159:96] = value;
                CFG_HASH_8_15:  exp_hash[95:32]  = value;
                CFG_HASH_16_19: exp_hash[31:0]   = value[31:0];
                CFG_PEER_0_7:   peer_id[159:96]  = value;
                CFG_PEER_8_15:  peer_id[95:32]   = value;
                CFG_PEER_16_19: peer_id[31:0]    = value[31:0];
                CFG_VERIFY:     verify           = value[0];
                default: ;
            endcase
        endfunction

        function void note_rx_byte(logic [7:0] b);
            result_t r;
            err_t    e;
            r.data_byte  = b;
            r.field_kind = phase;
            r.msg_start  = 1'b0;
            r.msg_last   = 1'b0;
            r.keepalive  = 1'b0;
            e = ERR_NONE;
            if (held_err != ERR_NONE) begin
                // frozen: pass the byte through with the latched code
                r.error_code = held_err;
                expected_tags.insert(expected_tags.size(), r);
                return;
            end
            case (phase)
                PH_PLEN: begin
                    if (b != 8'd19) begin
                        e = ERR_PROTO_LEN;
                    end else begin
                        phase   = PH_PSTR;
                        count   = 0;
                        differs = 1'b0;
                    end
                end
                PH_PSTR: begin
                    if (b != PROTOCOL_NAME[8*(PSTR_LEN-1-count) +: 8]) differs = 1'b1;
                    count++;
                    if (count >= PSTR_LEN) begin
                        if (differs) begin
                            e = ERR_STRING;
                        end else begin
                            phase = PH_RSV;
                            count = 0;
                        end
                    end
                end
                PH_RSV: begin
                    count++;
                    if (count >= RSV_LEN) begin
                        phase   = PH_HASH;
                        count   = 0;
                        differs = 1'b0;
                    end
                end
                PH_HASH: begin
                    if (b != exp_hash[8*(ID_BYTES-1-count) +: 8]) differs = 1'b1;
                    count++;
                    if (count >= ID_BYTES) begin
                        if (differs) begin
                            e = ERR_HASH;
                        end else begin
                            phase   = PH_PEER;
                            count   = 0;
                            differs = 1'b0;
                        end
                    end
                end
                PH_PEER: begin
                    if (b != peer_id[8*(ID_BYTES-1-count) +: 8]) differs = 1'b1;
                    count++;
                    if (count >= ID_BYTES) begin
                        if (differs && verify) begin
                            e = ERR_PEER;
                        end else begin
                            phase     = PH_LEN;
                            count     = 0;
                            len_accum = '0;
                            differs   = 1'b0;
                        end
                    end
                end
                PH_LEN: begin
                    len_accum = {len_accum[23:0], b};
                    count++;
                    if (count >= 4) begin
                        count = 0;
                        if (len_accum > MAX_MESSAGE_DEF) begin
                            e = ERR_TOO_LONG;
                        end else if (len_accum == 0) begin
                            r.keepalive = 1'b1;
                        end else begin
                            msg_len = len_accum;
                            phase   = PH_TYPE;
                        end
                        len_accum = '0;
                    end
                end
                PH_TYPE: begin
                    r.msg_start = 1'b1;
                    if (b > MAX_MSG_TYPE) begin
                        e = ERR_BAD_TYPE;
                    end else if (msg_len <= 1) begin
                        r.msg_last = 1'b1;
                        phase      = PH_LEN;
                        count      = 0;
                    end else begin
                        phase = PH_PAY;
                        count = 1;
                    end
                end
                default: begin
                    count++;
                    if (count >= msg_len) begin
                        r.msg_last = 1'b1;
                        phase      = PH_LEN;
                        count      = 0;
                    end
                end
            endcase
            if (e != ERR_NONE) held_err = e;
            r.error_code = e;
            expected_tags.insert(expected_tags.size(), r);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_tags.size() == 0) begin
                faults++;
                if (faults <= REPORT_LIMIT)
                    $display("[%0t] unexpected result: byte %02h kind %0d err %0d",
                             $realtime, got.data_byte, got.field_kind, got.error_code);
                return;
            end
            want = expected_tags.pop_front();
            checked++;
            if (got.msg_last === 1'b1) msgs_closed++;
            if (got.keepalive === 1'b1) keepalives++;
            if (got.data_byte !== want.data_byte || got.field_kind !== want.field_kind ||
                got.msg_start !== want.msg_start || got.msg_last !== want.msg_last ||
                got.keepalive !== want.keepalive || got.error_code !== want.error_code) begin
                faults++;
                if (faults <= REPORT_LIMIT)
                    $display({"[%0t] mismatch on result %0d: got byte %02h kind %0d start %b",
                              " last %b keep %b err %0d, expected byte %02h kind %0d start %b",
                              " last %b keep %b err %0d"},
                             $realtime, checked, got.data_byte, got.field_kind, got.msg_start,
                             got.msg_last, got.keepalive, got.error_code, want.data_byte,
                             want.field_kind, want.msg_start, want.msg_last, want.keepalive,
                             want.error_code);
            end
        endfunction
    endclass

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    logic [7:0]             s_rx_byte = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    logic [7:0]             m_data_byte;
    logic [2:0]             m_field_kind;
    logic                   m_msg_start;
    logic                   m_msg_last;
    logic                   m_keepalive;
    logic [2:0]             m_error_code;

    byte_tag_scoreboard    tags;
    logic [7:0]            wire_bytes[$];
    logic [8*ID_BYTES-1:0] cfg_hash;
    logic [8*ID_BYTES-1:0] cfg_peer;
    bit                    cfg_verify;
    bit                    steady       = 1'b0;
    int unsigned           quiet_cycles = 0;

    peer_wire_handshake_deframer_core uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_rx_byte    (s_rx_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data_byte  (m_data_byte),
        .m_field_kind (m_field_kind),
        .m_msg_start  (m_msg_start),
        .m_msg_last   (m_msg_last),
        .m_keepalive  (m_keepalive),
        .m_error_code (m_error_code)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge aclk) begin
        result_t seen;
        if (aresetn) begin
            if (s_valid && s_ready) tags.note_rx_byte(s_rx_byte);
            if (m_valid && m_ready) begin
                seen.data_byte  = m_data_byte;
                seen.field_kind = phase_t'(m_field_kind);
                seen.msg_start  = m_msg_start;
                seen.msg_last   = m_msg_last;
                seen.keepalive  = m_keepalive;
                seen.error_code = err_t'(m_error_code);
                tags.check_result(seen);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL peer_wire_handshake_deframer_core");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [7:0] any_byte();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Append one byte to the outgoing stream.
    function automatic void add_byte(logic [7:0] b);
        wire_bytes.insert(wire_bytes.size(), b);
    endfunction

    function automatic void push_prefix(logic [31:0] len);
        for (int i = 3; i >= 0; i--) add_byte(len[8*i +: 8]);
    endfunction

    function automatic void push_message(logic [31:0] len, logic [7:0] kind);
        push_prefix(len);
        if (len != 0) begin
            add_byte(kind);
            for (int i = 1; i < len; i++) add_byte(any_byte());
        end
    endfunction

    // Mostly short messages, some keepalives, now and then one past 255 bytes.
    function automatic void push_traffic(int unsigned budget);
        int unsigned roll;
        int unsigned len;
        while (wire_bytes.size() < budget) begin
            roll = $urandom_range(0, 99);
            if (roll < 10)      len = 0;
            else if (roll < 20) len = 1;
            else if (roll < 97) len = $urandom_range(2, 16);
            else                len = $urandom_range(17, 300);
            push_message(len, 8'($urandom_range(0, MAX_MSG_TYPE)));
        end
    endfunction

    // Push a 20-byte id, optionally with one bit flipped somewhere.
    function automatic void push_id(logic [8*ID_BYTES-1:0] id, bit corrupt);
        int unsigned spot;
        logic [7:0]  b;
        spot = $urandom_range(0, ID_BYTES - 1);
        for (int i = 0; i < ID_BYTES; i++) begin
            b = id[8*(ID_BYTES-1-i) +: 8];
            if (corrupt && i == spot) b = b ^ 8'(1 << $urandom_range(0, 7));
            add_byte(b);
        end
    endfunction

    task automatic load_ids(input logic [8*ID_BYTES-1:0] h, input logic [8*ID_BYTES-1:0] p,
                            input bit v);
        logic [CFG_DATA_W-1:0] word [0:6];
        cfg_index_t            idx;
        cfg_hash   = h;
        cfg_peer   = p;
        cfg_verify = v;
        // upper bits of the narrow registers carry junk that must be ignored
        word[CFG_HASH_0_7]   = h[159:96];
        word[CFG_HASH_8_15]  = h[95:32];
        word[CFG_HASH_16_19] = {$urandom, h[31:0]};
        word[CFG_PEER_0_7]   = p[159:96];
        word[CFG_PEER_8_15]  = p[95:32];
        word[CFG_PEER_16_19] = {$urandom, p[31:0]};
        word[CFG_VERIFY]     = {$urandom, $urandom};
        word[CFG_VERIFY][0]  = v;
        idx = idx.first();
        for (int n = 0; n < idx.num(); n++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= idx;
            cfg_wdata <= word[idx];
            @(posedge aclk);
            tags.write_reg(idx, word[idx]);
            idx = idx.next();
        end
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_stream();
        while (wire_bytes.size() > 0) begin
            if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end else begin
                s_valid   <= 1'b1;
                s_rx_byte <= wire_bytes.pop_front();
                @(posedge aclk);
                while (!s_ready) @(posedge aclk);
            end
        end
        s_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        @(posedge aclk);
        while (tags.expected_tags.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        err_t                  hs_fault;
        err_t                  tail_fault;
        logic [8*ID_BYTES-1:0] h;
        logic [8*ID_BYTES-1:0] p;
        logic [31:0]           len;
        logic [7:0]            b;
        int unsigned           spot;
        tags = new();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Handshake ids: all zero, all one or random.
        case ($urandom_range(0, 2))
            0:       begin h = '0; p = '0; end
            1:       begin h = '1; p = '1; end
            default: begin
                h = {$urandom, $urandom, $urandom, $urandom, $urandom};
                p = {$urandom, $urandom, $urandom, $urandom, $urandom};
            end
        endcase
        case ($urandom_range(0, 15))
            0:       hs_fault = ERR_PROTO_LEN;
            1:       hs_fault = ERR_STRING;
            2:       hs_fault = ERR_HASH;
            3:       hs_fault = ERR_PEER;
            default: hs_fault = ERR_NONE;
        endcase
        load_ids(h, p, (hs_fault == ERR_PEER) ? 1'b1 : 1'($urandom_range(0, 1)));

        b = 8'd19;
        if (hs_fault == ERR_PROTO_LEN) begin
            do b = any_byte(); while (b == 8'd19);
        end
        add_byte(b);
        spot = $urandom_range(0, PSTR_LEN - 1);
        for (int i = 0; i < PSTR_LEN; i++) begin
            b = PROTOCOL_NAME[8*(PSTR_LEN-1-i) +: 8];
            if (hs_fault == ERR_STRING && i == spot) b = b ^ 8'(1 << $urandom_range(0, 7));
            add_byte(b);
        end
        repeat (RSV_LEN) add_byte(any_byte());
        push_id(cfg_hash, hs_fault == ERR_HASH);
        // an unchecked peer id may differ freely
        push_id(cfg_peer, hs_fault == ERR_PEER || (!cfg_verify && $urandom_range(0, 1) == 1));

        // keepalive, type-only message, highest legal type, short payloads
        push_message(0, 8'd0);
        push_message(1, 8'd0);
        push_message(2, 8'(MAX_MSG_TYPE));
        push_message(3, 8'($urandom_range(0, MAX_MSG_TYPE)));
        push_message(0, 8'd0);
        send_stream();
        wait_drained();

        load_ids('1, '1, 1'b1);
        push_traffic(700);
        send_stream();
        // hold the sender until every result is back
        wait_drained();

        load_ids('0, '0, 1'b0);
        steady = 1'b1;
        push_traffic(350);
        send_stream();
        steady = 1'b0;
        push_traffic(350);
        send_stream();
        wait_drained();

        load_ids({$urandom, $urandom, $urandom, $urandom, $urandom},
                 {$urandom, $urandom, $urandom, $urandom, $urandom}, 1'($urandom_range(0, 1)));
        case ($urandom_range(0, 2))
            0:       tail_fault = ERR_TOO_LONG;
            1:       tail_fault = ERR_BAD_TYPE;
            default: tail_fault = ERR_NONE;
        endcase
        case (tail_fault)
            ERR_TOO_LONG: begin
                case ($urandom_range(0, 2))
                    0:       len = MAX_MESSAGE_DEF + 1;
                    1:       len = '1;
                    default: len = $urandom_range(MAX_MESSAGE_DEF + 2, 32'hFFFF_FFFF);
                endcase
                push_prefix(len);
            end
            ERR_BAD_TYPE: begin
                push_prefix($urandom_range(1, 16));
                case ($urandom_range(0, 2))
                    0:       add_byte(8'(MAX_MSG_TYPE + 1));
                    1:       add_byte(8'hFF);
                    default: add_byte(8'($urandom_range(MAX_MSG_TYPE + 2, 254)));
                endcase
            end
            default: begin
                // largest legal message; the run ends inside its payload
                push_prefix(MAX_MESSAGE_DEF);
                add_byte(8'($urandom_range(0, MAX_MSG_TYPE)));
            end
        endcase
        repeat (TAIL_BYTES) add_byte(any_byte());
        send_stream();
        wait_drained();

        $display("Tagged %0d bytes: %0d messages closed, %0d keepalives.",
                 tags.checked, tags.msgs_closed, tags.keepalives);
        $display("Handshake fault tried %s, stream fault tried %s, code held at end %s.",
                 hs_fault.name(), tail_fault.name(), tags.held_err.name());
        if (tags.faults == 0 && tags.expected_tags.size() == 0) begin
            $display("PASS peer_wire_handshake_deframer_core");
        end else begin
            $display("FAIL peer_wire_handshake_deframer_core");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hdl/pwdf_pkg.sv
hdl/pwdf_cfg_regs.sv
hdl/pwdf_parser.sv
hdl/peer_wire_handshake_deframer_core.sv
tb/sv/tb_peer_wire_handshake_deframer_core.sv
